@@ hw/rtl/grna_osa_pkg.sv @@
// ----------------------------------------------------------------------------
// grna_osa_pkg: shared types and constants for the off-target accumulator
// Item types, state encoding, fixed-point constants and the weight tables.
// ----------------------------------------------------------------------------
package grna_osa_pkg;

    localparam int GUIDE_LENGTH = 20;
    localparam int BASES_W      = 2 * GUIDE_LENGTH;
    localparam int POS_W        = 5;     // holds 0..GUIDE_LENGTH
    localparam int Q_W          = 17;    // Q1.16 with 1.0 as 65536
    localparam int SCORE_W      = 23;
    localparam int SUM_W        = 48;
    localparam int TALLY_W      = 32;
    localparam int DIV_W        = 50;    // dividend / quotient shift register
    localparam int DSR_W        = 49;    // divisor and remainder
    localparam int CFG_IDX_W    = 8;

    localparam logic [Q_W-1:0]     Q_ONE           = 17'd65536;
    localparam logic [Q_W-1:0]     FACTOR_FIFTH    = 17'd13107;
    localparam logic [Q_W-1:0]     FACTOR_NAG_PAIR = 17'd16991;
    localparam logic [SCORE_W-1:0] FULL_SCORE      = 23'd6553600;
    localparam logic [SCORE_W-1:0] POS_FLOOR       = 23'd3276;
    localparam logic [SCORE_W-1:0] PAIR_FLOOR      = 23'd150732;
    localparam logic [DIV_W-1:0]   AGG_NUMERATOR   = 50'd42949672960000; // 10000 << 32

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCORING_METHOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TARGET      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAM_TYPE       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAM_LEAD       = 8'd3;

    // PAM type codes
    localparam logic [1:0] PAM_NGG  = 2'd1;
    localparam logic [1:0] PAM_TTTV = 2'd2;

    // Base codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;

    typedef struct packed {
        logic [BASES_W-1:0] off_target_bases;
        logic               last_of_list;
    } t_in_item;

    typedef struct packed {
        logic [SCORE_W-1:0] aggregate_score;
        logic [SCORE_W-1:0] best_hit_score;
        logic [TALLY_W-1:0] counted_hits;
        logic               exact_found;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_WALK,
        S_PAM,
        S_MUL100,
        S_K_NUM,
        S_K_SQ,
        S_K_DEN,
        S_K_DVD,
        S_DIV_LOAD,
        S_DIV,
        S_ACC,
        S_FIN_LOAD,
        S_OUT
    } t_state;

    localparam logic [Q_W-1:0] POS_KEEP [0:GUIDE_LENGTH-1] = '{
        17'd65536, 17'd65536, 17'd64618, 17'd65536, 17'd65536,
        17'd39649, 17'd44761, 17'd65536, 17'd40042, 17'd60359,
        17'd36372, 17'd32244, 17'd25362, 17'd9765,  17'd17564,
        17'd11272, 17'd25231, 17'd12845, 17'd20644, 17'd27329
    };

    // Row per position: on-target (A,T,G,C) by complemented off-target (T,A,C,G)
    localparam logic [Q_W-1:0] PAIR_WEIGHT [0:16*GUIDE_LENGTH-1] = '{
        17'd65536,17'd65536,17'd56174,17'd65536, 17'd65536,17'd65536,17'd56174,17'd62687,
        17'd65536,17'd58982,17'd46811,17'd65536, 17'd65536,17'd65536,17'd65536,17'd59837,
        17'd47663,17'd65536,17'd51493,17'd52429, 17'd65536,17'd55454,17'd56174,17'd55050,
        17'd41705,17'd55454,17'd45371,17'd65536, 17'd59578,17'd47663,17'd65536,17'd45590,
        17'd46261,17'd65536,17'd28087,17'd40050, 17'd65536,17'd46811,17'd28087,17'd32768,
        17'd32768,17'd49152,17'd25206,17'd65536, 17'd45056,17'd56798,17'd65536,17'd32768,
        17'd41705,17'd65536,17'd23130,17'd40960, 17'd65536,17'd31208,17'd42406,17'd40960,
        17'd23831,17'd58982,17'd34696,17'd65536, 17'd52429,17'd55188,17'd65536,17'd32768,
        17'd23831,17'd65536,17'd32768,17'd47186, 17'd65536,17'd32768,17'd65536,17'd41943,
        17'd19661,17'd56798,17'd51493,17'd65536, 17'd41705,17'd37449,17'd65536,17'd39322,
        17'd46811,17'd65536,17'd29789,17'd46811, 17'd65536,17'd56798,17'd59578,17'd37449,
        17'd43691,17'd65536,17'd44684,17'd65536, 17'd60855,17'd60855,17'd65536,17'd32768,
        17'd28672,17'd65536,17'd28672,17'd46261, 17'd65536,17'd57344,17'd45056,17'd38551,
        17'd37449,17'd65536,17'd45056,17'd65536, 17'd53248,17'd49152,17'd65536,17'd30840,
        17'd28087,17'd65536,17'd28087,17'd48060, 17'd65536,17'd52429,17'd65536,17'd48060,
        17'd40960,17'd65536,17'd40330,17'd65536, 17'd57344,17'd42598,17'd65536,17'd42130,
        17'd39322,17'd65536,17'd37449,17'd43691, 17'd65536,17'd60855,17'd60495,17'd40570,
        17'd34953,17'd42130,17'd35289,17'd65536, 17'd57344,17'd56174,17'd65536,17'd40570,
        17'd57826,17'd65536,17'd21845,17'd36409, 17'd65536,17'd56174,17'd34953,17'd32768,
        17'd53248,17'd61167,17'd26214,17'd65536, 17'd61681,17'd56798,17'd65536,17'd25486,
        17'd20165,17'd65536,17'd26214,17'd42598, 17'd65536,17'd49152,17'd43691,17'd26214,
        17'd25206,17'd65536,17'd28087,17'd65536, 17'd20165,17'd49152,17'd65536,17'd16384,
        17'd21845,17'd65536,17'd17246,17'd47332, 17'd65536,17'd52429,17'd62087,17'd32768,
        17'd25206,17'd61167,17'd34696,17'd65536, 17'd35289,17'd46811,17'd65536,17'd29127,
        17'd19661,17'd65536,17'd13797,17'd42741, 17'd65536,17'd45371,17'd51739,17'd17096,
        17'd19661,17'd60495,17'd27594,17'd65536, 17'd45875,17'd25206,17'd65536,17'd8937,
        17'd34953,17'd65536,17'd14043,17'd30583, 17'd65536,17'd40570,17'd18725,17'd0,
        17'd17476,17'd49152,17'd28087,17'd65536, 17'd48060,17'd22938,17'd65536,17'd0,
        17'd13107,17'd65536,17'd17873,17'd42598, 17'd65536,17'd37942,17'd17873,17'd3277,
        17'd9362, 17'd61681,17'd17873,17'd65536, 17'd4369, 17'd14564,17'd65536,17'd3277,
        17'd0,    17'd65536,17'd0,    17'd12603, 17'd65536,17'd59578,17'd43691,17'd22686,
        17'd0,    17'd65536,17'd0,    17'd65536, 17'd20165,17'd65536,17'd65536,17'd10082,
        17'd8738, 17'd65536,17'd11565,17'd11565, 17'd65536,17'd34953,17'd46261,17'd7710,
        17'd16384,17'd61167,17'd15420,17'd65536, 17'd30583,17'd30583,17'd65536,17'd3855,
        17'd32768,17'd65536,17'd12483,17'd26214, 17'd65536,17'd43691,17'd28087,17'd21845,
        17'd43691,17'd45371,17'd31208,17'd65536, 17'd42130,17'd35289,17'd65536,17'd8738,
        17'd35289,17'd65536,17'd13559,17'd24576, 17'd65536,17'd18725,17'd18079,17'd16384,
        17'd43691,17'd46811,17'd29378,17'd65536, 17'd30247,17'd28087,17'd65536,17'd8192,
        17'd39322,17'd65536,17'd14895,17'd50116, 17'd65536,17'd36864,17'd5958, 17'd11565,
        17'd45875,17'd61440,17'd28087,17'd65536, 17'd19661,17'd32768,17'd65536,17'd3855
    };

    // Base code to table row (on-target) and column (complemented off-target)
    function automatic logic [1:0] on_slot(input logic [1:0] base);
        logic [1:0] slot;
        unique case (base)
            2'd0:    slot = 2'd0;
            2'd1:    slot = 2'd3;
            2'd2:    slot = 2'd2;
            default: slot = 2'd1;
        endcase
        return slot;
    endfunction

    function automatic logic [1:0] off_slot(input logic [1:0] base);
        return base + 2'd1;
    endfunction

endpackage

@@ hw/rtl/grna_offtarget_score_accumulator.sv @@
// Items are taken one at a time: one shared 17x17 multiplier walks the 20
//   positions, plus a 32-step shift-subtract divide for the position method
//   with two or more mismatches; the next item waits until this is through.
// A last item adds a 50-step aggregate divide; the result sits in an output
//   register and the next item may enter meanwhile.
// Reset (synchronous, active low) clears configuration and accumulators.
// ----------------------------------------------------------------------------
// grna_offtarget_score_accumulator
// Scores off-target guides against the configured guide and accumulates hits.
// ----------------------------------------------------------------------------
module grna_offtarget_score_accumulator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [grna_osa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [grna_osa_pkg::BASES_W-1:0]       i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  grna_osa_pkg::t_in_item                 i_in_item,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output grna_osa_pkg::t_out_item                o_out_item
);

    localparam int QW = grna_osa_pkg::Q_W;
    localparam int PW = grna_osa_pkg::POS_W;

    // configuration
    logic                               r_method;
    logic [grna_osa_pkg::BASES_W-1:0]   r_on_bases;
    logic [1:0]                         r_pam_type;
    logic [3:0]                         r_pam_lead;

    // per-item working registers
    grna_osa_pkg::t_state               r_state, n_state;
    grna_osa_pkg::t_in_item             r_item;
    logic [PW-1:0]                      r_pos;
    logic [QW-1:0]                      r_wt;
    logic [QW-1:0]                      r_p;
    logic [PW-1:0]                      r_nmis;
    logic [PW-1:0]                      r_first;
    logic [PW-1:0]                      r_last;
    logic [10:0]                        r_a;      // 95 * (n - 1)
    logic [8:0]                         r_b;      // n * n
    logic [19:0]                        r_den;
    logic [31:0]                        r_dvd;
    logic [grna_osa_pkg::SCORE_W-1:0]   r_score;

    // shared divider
    logic [grna_osa_pkg::DIV_W-1:0]     r_quo;
    logic [grna_osa_pkg::DSR_W-1:0]     r_rem;
    logic [grna_osa_pkg::DSR_W-1:0]     r_dsr;
    logic [5:0]                         r_cnt;
    logic                               r_final;

    // accumulators
    logic [grna_osa_pkg::SUM_W-1:0]     r_hit_sum;
    logic [grna_osa_pkg::SCORE_W-1:0]   r_best;
    logic [grna_osa_pkg::TALLY_W-1:0]   r_tally;
    logic                               r_exact;

    logic                               r_out_valid;
    grna_osa_pkg::t_out_item            r_out_item;

    // combinational
    logic [QW-1:0]                      mul_a, mul_b;
    logic [2*QW-1:0]                    prod;
    logic [2*QW:0]                      prod_sum;
    logic [QW-1:0]                      prod_rnd;
    logic [QW-1:0]                      pam_factor;
    logic [1:0]                         on_base, off_base;
    logic                               mismatch;
    logic [QW-1:0]                      fetch_wt;
    logic                               fetching;
    logic [grna_osa_pkg::DIV_W-1:0]     div_shift;
    logic [grna_osa_pkg::DIV_W:0]       div_trial;
    logic [grna_osa_pkg::DSR_W-1:0]     fin_den;
    logic [PW-1:0]                      span;
    logic [grna_osa_pkg::SCORE_W-1:0]   floor_val;
    logic [grna_osa_pkg::SUM_W:0]       sum_ext;
    logic                               out_free;
    logic                               in_accept;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign span      = r_last - r_first;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method   <= 1'b0;
            r_on_bases <= '0;
            r_pam_type <= '0;
            r_pam_lead <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                grna_osa_pkg::CFG_SCORING_METHOD: r_method   <= i_cfg_data[0];
                grna_osa_pkg::CFG_ON_TARGET:      r_on_bases <= i_cfg_data;
                grna_osa_pkg::CFG_PAM_TYPE:       r_pam_type <= i_cfg_data[1:0];
                grna_osa_pkg::CFG_PAM_LEAD:       r_pam_lead <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // PAM factor
    always_comb begin
        if (r_pam_type == grna_osa_pkg::PAM_NGG && r_pam_lead[3:2] == grna_osa_pkg::BASE_A) begin
            pam_factor = r_method ? grna_osa_pkg::FACTOR_NAG_PAIR : grna_osa_pkg::FACTOR_FIFTH;
        end else if (r_pam_type == grna_osa_pkg::PAM_TTTV
                     && r_pam_lead[1:0] == grna_osa_pkg::BASE_C) begin
            pam_factor = grna_osa_pkg::FACTOR_FIFTH;
        end else begin
            pam_factor = grna_osa_pkg::Q_ONE;
        end
    end

    // weight fetch for position r_pos
    assign fetching = (r_state == grna_osa_pkg::S_FETCH)
                   || (r_state == grna_osa_pkg::S_WALK
                       && r_pos != PW'(grna_osa_pkg::GUIDE_LENGTH));
    assign on_base  = r_on_bases[2*r_pos +: 2];
    assign off_base = r_item.off_target_bases[2*r_pos +: 2];
    assign mismatch = on_base != off_base;

    // weight table read, registered
    always_ff @(posedge i_clk) begin
        if (fetching) begin
            r_wt <= fetch_wt;
        end
    end

    always_comb begin
        if (r_method) begin
            fetch_wt = grna_osa_pkg::PAIR_WEIGHT[{r_pos, grna_osa_pkg::on_slot(on_base),
                                                  grna_osa_pkg::off_slot(off_base)}];
        end else if (mismatch) begin
            fetch_wt = grna_osa_pkg::POS_KEEP[r_pos];
        end else begin
            fetch_wt = grna_osa_pkg::Q_ONE;
        end
    end

    // ---------------- shared multiplier ----------------
    assign prod     = mul_a * mul_b;
    assign prod_sum = {1'b0, prod} + (2*QW+1)'(32768);
    assign prod_rnd = prod_sum[QW+15:16];

    // ---------------- shared divider step ----------------
    assign div_shift = {r_rem, r_quo[grna_osa_pkg::DIV_W-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, r_dsr};
    assign fin_den   = {1'b0, r_hit_sum} + grna_osa_pkg::DSR_W'(grna_osa_pkg::FULL_SCORE);

    assign floor_val = r_method ? grna_osa_pkg::PAIR_FLOOR : grna_osa_pkg::POS_FLOOR;
    assign sum_ext   = {1'b0, r_hit_sum} + (grna_osa_pkg::SUM_W+1)'(r_score);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            grna_osa_pkg::S_IDLE:     if (i_in_valid) n_state = grna_osa_pkg::S_FETCH;
            grna_osa_pkg::S_FETCH:    n_state = grna_osa_pkg::S_WALK;
            grna_osa_pkg::S_WALK: begin
                if (r_pos == PW'(grna_osa_pkg::GUIDE_LENGTH)) n_state = grna_osa_pkg::S_PAM;
            end
            grna_osa_pkg::S_PAM: begin
                if (r_method || r_nmis < PW'(2)) n_state = grna_osa_pkg::S_MUL100;
                else                             n_state = grna_osa_pkg::S_K_NUM;
            end
            grna_osa_pkg::S_MUL100:   n_state = grna_osa_pkg::S_ACC;
            grna_osa_pkg::S_K_NUM:    n_state = grna_osa_pkg::S_K_SQ;
            grna_osa_pkg::S_K_SQ:     n_state = grna_osa_pkg::S_K_DEN;
            grna_osa_pkg::S_K_DEN:    n_state = grna_osa_pkg::S_K_DVD;
            grna_osa_pkg::S_K_DVD:    n_state = grna_osa_pkg::S_DIV_LOAD;
            grna_osa_pkg::S_DIV_LOAD: n_state = grna_osa_pkg::S_DIV;
            grna_osa_pkg::S_DIV: begin
                if (r_cnt == 6'd1) begin
                    n_state = r_final ? grna_osa_pkg::S_OUT : grna_osa_pkg::S_ACC;
                end
            end
            grna_osa_pkg::S_ACC: begin
                n_state = r_item.last_of_list ? grna_osa_pkg::S_FIN_LOAD : grna_osa_pkg::S_IDLE;
            end
            grna_osa_pkg::S_FIN_LOAD: n_state = grna_osa_pkg::S_DIV;
            grna_osa_pkg::S_OUT:      if (out_free) n_state = grna_osa_pkg::S_IDLE;
            default:                  n_state = grna_osa_pkg::S_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb begin
        o_in_ready = 1'b0;
        mul_a      = r_p;
        mul_b      = r_wt;
        unique case (r_state)
            grna_osa_pkg::S_IDLE:   o_in_ready = 1'b1;
            grna_osa_pkg::S_PAM:    mul_b = pam_factor;
            grna_osa_pkg::S_MUL100: mul_b = QW'(100);
            grna_osa_pkg::S_K_NUM: begin
                mul_a = QW'(r_nmis - PW'(1));
                mul_b = QW'(95);
            end
            grna_osa_pkg::S_K_SQ: begin
                mul_a = QW'(r_nmis);
                mul_b = QW'(r_nmis);
            end
            grna_osa_pkg::S_K_DEN: begin
                mul_a = QW'(r_b);
                mul_b = QW'(r_a - {4'b0, span, 2'b00});
            end
            grna_osa_pkg::S_K_DVD: mul_b = QW'({r_a, 4'b0000}) + QW'({r_a, 2'b00});
            default: ;
        endcase
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grna_osa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item  <= i_in_item;
            r_pos   <= '0;
            r_p     <= grna_osa_pkg::Q_ONE;
            r_nmis  <= '0;
            r_first <= '0;
            r_last  <= '0;
        end else begin
            if (fetching) begin
                r_pos <= r_pos + PW'(1);
                if (mismatch) begin
                    if (r_nmis == '0) r_first <= r_pos;
                    r_last <= r_pos;
                    r_nmis <= r_nmis + PW'(1);
                end
            end
            if (r_state == grna_osa_pkg::S_WALK || r_state == grna_osa_pkg::S_PAM) begin
                r_p <= prod_rnd;
            end
        end
        if (r_state == grna_osa_pkg::S_K_NUM) r_a   <= prod[10:0];
        if (r_state == grna_osa_pkg::S_K_SQ)  r_b   <= prod[8:0];
        if (r_state == grna_osa_pkg::S_K_DEN) r_den <= prod[19:0];
        if (r_state == grna_osa_pkg::S_K_DVD) r_dvd <= prod[31:0];
        if (r_state == grna_osa_pkg::S_MUL100) begin
            r_score <= prod[grna_osa_pkg::SCORE_W-1:0];
        end else if (r_state == grna_osa_pkg::S_DIV && r_cnt == 6'd1 && !r_final) begin
            r_score <= div_trial[grna_osa_pkg::DIV_W] ? r_quo[grna_osa_pkg::SCORE_W-2:0] << 1
                     : {r_quo[grna_osa_pkg::SCORE_W-2:0], 1'b1};
        end
    end

    // divider: one quotient bit a cycle, rounded dividend
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            grna_osa_pkg::S_DIV_LOAD: begin
                r_final <= 1'b0;
                r_cnt   <= 6'd32;
                r_rem   <= '0;
                r_dsr   <= grna_osa_pkg::DSR_W'(r_den);
                r_quo   <= {(grna_osa_pkg::DIV_W-32)'(0), r_dvd + 32'(r_den[19:1])}
                           << (grna_osa_pkg::DIV_W - 32);
            end
            grna_osa_pkg::S_FIN_LOAD: begin
                r_final <= 1'b1;
                r_cnt   <= 6'(grna_osa_pkg::DIV_W);
                r_rem   <= '0;
                r_dsr   <= fin_den;
                r_quo   <= grna_osa_pkg::AGG_NUMERATOR
                           + grna_osa_pkg::DIV_W'(fin_den[grna_osa_pkg::DSR_W-1:1]);
            end
            grna_osa_pkg::S_DIV: begin
                r_cnt <= r_cnt - 6'd1;
                if (div_trial[grna_osa_pkg::DIV_W]) begin
                    r_rem <= div_shift[grna_osa_pkg::DSR_W-1:0];
                    r_quo <= {r_quo[grna_osa_pkg::DIV_W-2:0], 1'b0};
                end else begin
                    r_rem <= div_trial[grna_osa_pkg::DSR_W-1:0];
                    r_quo <= {r_quo[grna_osa_pkg::DIV_W-2:0], 1'b1};
                end
            end
            default: ;
        endcase
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_sum <= '0;
            r_best    <= '0;
            r_tally   <= '0;
            r_exact   <= 1'b0;
        end else if (r_state == grna_osa_pkg::S_ACC) begin
            if (r_score == grna_osa_pkg::FULL_SCORE && !r_exact) begin
                r_exact <= 1'b1;
            end else if (r_score > floor_val) begin
                // saturate the sum and the count
                r_hit_sum <= sum_ext[grna_osa_pkg::SUM_W] ? '1
                           : sum_ext[grna_osa_pkg::SUM_W-1:0];
                if (r_score > r_best) r_best <= r_score;
                if (r_tally != '1) r_tally <= r_tally + grna_osa_pkg::TALLY_W'(1);
            end
        end else if (r_state == grna_osa_pkg::S_OUT && out_free) begin
            r_hit_sum <= '0;
            r_best    <= '0;
            r_tally   <= '0;
            r_exact   <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == grna_osa_pkg::S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == grna_osa_pkg::S_OUT && out_free) begin
            r_out_item.aggregate_score <= r_quo[grna_osa_pkg::SCORE_W-1:0];
            r_out_item.best_hit_score  <= r_best;
            r_out_item.counted_hits    <= r_tally;
            r_out_item.exact_found     <= r_exact;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ---------------- assertions ----------------
    a_rem_below_dsr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == grna_osa_pkg::S_DIV |-> r_rem < r_dsr)
        else $error("divider remainder not below divisor");

    a_mismatch_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nmis != '0 |-> (r_first <= r_last && r_nmis <= PW'(grna_osa_pkg::GUIDE_LENGTH)))
        else $error("mismatch span inconsistent");

    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == grna_osa_pkg::S_OUT)
        else $error("result raised outside final step");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == grna_osa_pkg::S_OUT && out_free) |=>
            (r_hit_sum == '0 && r_tally == '0 && r_best == '0 && !r_exact))
        else $error("accumulators not cleared after result");

endmodule
